// File: rtl/srw_pkg.sv
package srw_pkg;

   localparam int PRIO_W    = 16;
   localparam int WGT_W     = 16;
   localparam int RND_W     = 32;
   localparam int INDEX_W   = 6;
   localparam int ERR_W     = 3;
   localparam int DIV_CNT_W = $clog2(RND_W + 1);

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE       = 3'd0,
      ERR_EMPTY      = 3'd1,
      ERR_ZERO_SUM   = 3'd2,
      ERR_BLANK      = 3'd3,
      ERR_OVER_LIMIT = 3'd4
   } err_kind_type;

   typedef struct packed {
      logic              blank;
      logic [WGT_W-1:0]  wgt;
      logic [PRIO_W-1:0] prio;
   } record_type;

   // controller -> datapath
   typedef struct packed {
      logic         load;
      logic         sum_clear;
      logic         scan_clear;
      logic         scan_run;
      logic         sum_pass;
      logic         pick_pass;
      logic         div_clear;
      logic         div_step;
      logic         set_result;
      err_kind_type err_kind;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic set_empty;
      logic set_overflow;
      logic scan_done;
      logic sum_zero;
      logic sum_over;
      logic div_done;
      logic hit;
      logic hit_blank;
   } dp_status_type;

endpackage

// File: rtl/srw_ram.sv
module srw_ram import srw_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/srw_datapath.sv
module srw_datapath import srw_pkg::*; #(
   parameter int MAX_RECORDS    = 64,
   parameter int MAX_WEIGHT_SUM = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [PRIO_W-1:0]  req_priority,
   input  logic [WGT_W-1:0]   req_weight,
   input  logic               req_blank,
   input  logic [RND_W-1:0]   req_random,
   output logic               res_found,
   output logic [INDEX_W-1:0] res_index,
   output logic [ERR_W-1:0]   res_error
);

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   // sum stops growing once past the limit, so it never exceeds limit + one weight
   localparam int SUM_W = $clog2(MAX_WEIGHT_SUM + (1 << WGT_W));
   localparam int REM_W = SUM_W + 1;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PRIO_W-1:0]    lowest_ff, lowest_in;
   logic                 overflow_ff, overflow_in;
   logic [RND_W-1:0]     rnd_ff, rnd_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 rvalid_ff, rvalid_in;
   logic [CNT_W-1:0]     ridx_ff, ridx_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 over_ff, over_in;
   logic [SUM_W-1:0]     run_ff, run_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 found_ff, found_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [ERR_W-1:0]     error_ff, error_in;

   logic       store;
   logic       rd_en;
   record_type wr_rec;
   record_type rd_rec;
   logic       match;
   logic [SUM_W-1:0] acc_sum;
   logic [SUM_W-1:0] run_sum;
   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] sum_ext;
   logic             hit;

   assign store  = cmd.load && (count_ff < CNT_W'(MAX_RECORDS));
   assign rd_en  = cmd.scan_run && (issue_ff < count_ff);
   assign wr_rec = '{blank: req_blank, wgt: req_weight, prio: req_priority};

   srw_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (MAX_RECORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_rec)
   );

   assign match     = rvalid_ff && (rd_rec.prio == lowest_ff);
   assign acc_sum   = sum_ff + SUM_W'(rd_rec.wgt);
   assign run_sum   = run_ff + SUM_W'(rd_rec.wgt);
   assign rem_shift = {rem_ff[SUM_W-1:0], rnd_ff[RND_W-1]};
   assign sum_ext   = {1'b0, sum_ff};
   assign hit       = cmd.pick_pass && match && ({1'b0, run_sum} > rem_ff);

   always_comb begin
      count_in    = count_ff;
      lowest_in   = lowest_ff;
      overflow_in = overflow_ff;
      rnd_in      = rnd_ff;
      issue_in    = issue_ff;
      rvalid_in   = rd_en;
      ridx_in     = issue_ff;
      sum_in      = sum_ff;
      over_in     = over_ff;
      run_in      = run_ff;
      rem_in      = rem_ff;
      div_cnt_in  = div_cnt_ff;
      found_in    = found_ff;
      index_in    = index_ff;
      error_in    = error_ff;

      // record loading
      if (cmd.load) begin
         rnd_in = req_random;
         if (store) begin
            count_in = count_ff + 1'b1;
            if (req_priority < lowest_ff) begin
               lowest_in = req_priority;
            end
         end else begin
            overflow_in = 1'b1;
         end
      end

      // table scan
      if (cmd.scan_clear) begin
         issue_in  = '0;
         rvalid_in = 1'b0;
         run_in    = '0;
      end else if (rd_en) begin
         issue_in = issue_ff + 1'b1;
      end

      if (cmd.sum_clear) begin
         sum_in  = '0;
         over_in = 1'b0;
      end else if (cmd.sum_pass && match && !over_ff) begin
         sum_in = acc_sum;
         if (acc_sum > SUM_W'(MAX_WEIGHT_SUM)) begin
            over_in = 1'b1;
         end
      end

      if (cmd.pick_pass && match) begin
         run_in = run_sum;
      end

      // restoring remainder, one dividend bit per step
      if (cmd.div_clear) begin
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rnd_in     = {rnd_ff[RND_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + 1'b1;
         if (rem_shift >= sum_ext) begin
            rem_in = rem_shift - sum_ext;
         end else begin
            rem_in = rem_shift;
         end
      end

      // result capture, also returns the set to empty
      if (cmd.set_result) begin
         error_in    = cmd.err_kind;
         found_in    = (cmd.err_kind == ERR_NONE);
         index_in    = (cmd.err_kind == ERR_NONE) ? INDEX_W'(ridx_ff) : '0;
         count_in    = '0;
         lowest_in   = '1;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         lowest_ff   <= '1;
         overflow_ff <= 1'b0;
         issue_ff    <= '0;
         rvalid_ff   <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         count_ff    <= count_in;
         lowest_ff   <= lowest_in;
         overflow_ff <= overflow_in;
         issue_ff    <= issue_in;
         rvalid_ff   <= rvalid_in;
         div_cnt_ff  <= div_cnt_in;
      end
      rnd_ff   <= rnd_in;
      ridx_ff  <= ridx_in;
      sum_ff   <= sum_in;
      over_ff  <= over_in;
      run_ff   <= run_in;
      rem_ff   <= rem_in;
      found_ff <= found_in;
      index_ff <= index_in;
      error_ff <= error_in;
   end

   assign status.set_empty    = (count_ff == '0);
   assign status.set_overflow = overflow_ff;
   assign status.scan_done    = (issue_ff == count_ff) && !rvalid_ff;
   assign status.sum_zero     = (sum_ff == '0);
   assign status.sum_over     = over_ff;
   assign status.div_done     = (div_cnt_ff == DIV_CNT_W'(RND_W));
   assign status.hit          = hit;
   assign status.hit_blank    = rd_rec.blank;

   assign res_found = found_ff;
   assign res_index = index_ff;
   assign res_error = error_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECORDS))
      else $error("record count beyond table depth");

   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.pick_pass |-> (rem_ff < sum_ext))
      else $error("remainder not reduced below weight sum");

endmodule

// File: rtl/srw_ctrl.sv
module srw_ctrl import srw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  logic          req_last,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          req_ready,
   output logic          rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK_SET,
      ST_SCAN_SUM,
      ST_SUM_CHECK,
      ST_DIVIDE,
      ST_PICK,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.err_kind = ERR_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_fire;
            if (req_fire && req_last) begin
               state_in     = ST_CHECK_SET;
               req_ready_in = 1'b0;
            end
         end
         ST_CHECK_SET: begin
            cmd.scan_clear = 1'b1;
            cmd.sum_clear  = 1'b1;
            if (status.set_empty) begin
               cmd.set_result = 1'b1;
               cmd.err_kind   = ERR_EMPTY;
               state_in       = ST_RESPOND;
               rsp_valid_in   = 1'b1;
            end else if (status.set_overflow) begin
               cmd.set_result = 1'b1;
               cmd.err_kind   = ERR_OVER_LIMIT;
               state_in       = ST_RESPOND;
               rsp_valid_in   = 1'b1;
            end else begin
               state_in = ST_SCAN_SUM;
            end
         end
         ST_SCAN_SUM: begin
            cmd.scan_run = 1'b1;
            cmd.sum_pass = 1'b1;
            if (status.scan_done) begin
               state_in = ST_SUM_CHECK;
            end
         end
         ST_SUM_CHECK: begin
            cmd.scan_clear = 1'b1;
            cmd.div_clear  = 1'b1;
            if (status.sum_zero) begin
               cmd.set_result = 1'b1;
               cmd.err_kind   = ERR_ZERO_SUM;
               state_in       = ST_RESPOND;
               rsp_valid_in   = 1'b1;
            end else if (status.sum_over) begin
               cmd.set_result = 1'b1;
               cmd.err_kind   = ERR_OVER_LIMIT;
               state_in       = ST_RESPOND;
               rsp_valid_in   = 1'b1;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = !status.div_done;
            if (status.div_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.scan_run  = 1'b1;
            cmd.pick_pass = 1'b1;
            if (status.hit) begin
               cmd.set_result = 1'b1;
               cmd.err_kind   = status.hit_blank ? ERR_BLANK : ERR_NONE;
               state_in       = ST_RESPOND;
               rsp_valid_in   = 1'b1;
            end
         end
         ST_RESPOND: begin
            if (rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("input ready while a result is pending");

   a_pick_hits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> !status.scan_done)
      else $error("pick scan ended without a hit");

endmodule

// File: rtl/srv_weighted_record_select.sv
// Weighted random selection among service records. Records stream in one per
// item on the req_ channel and are stored in arrival order in a table of
// MAX_RECORDS entries while the lowest priority is tracked. The item marked
// tlast is stored too and starts selection with its random word: the weights
// of the lowest-priority records are summed, the random word is reduced modulo
// that sum, and the first such record whose running sum exceeds the remainder
// is chosen. One result item follows each tlast item: found, the arrival index
// and an error code (empty set, zero sum, blank name, or sum over
// MAX_WEIGHT_SUM / table overflow). Records that are not last are taken back
// to back while the block is idle. A last record starts these steps in order:
// a check of the stored set, the summing scan through the single read port of
// the table, a check of the sum, the bit-serial remainder over the 32-bit
// random word, and the pick scan. An empty set or a table overflow is answered
// from the first check, a zero or too large sum from the second, without the
// later steps. No item is taken while a result waits on rsp_.
module srv_weighted_record_select import srw_pkg::*; #(
   parameter int MAX_RECORDS    = 64,
   parameter int MAX_WEIGHT_SUM = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // record channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // priority_req[15:0], weight[31:16], random_word[63:32]
   input  logic        req_tuser,   // name_blank
   input  logic        req_tlast,   // last record of the set
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // selected_index[5:0], error_kind[8:6], zero pad
   output logic        rsp_tuser    // found
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               req_fire;
   logic               res_found;
   logic [INDEX_W-1:0] res_index;
   logic [ERR_W-1:0]   res_error;

   assign req_fire = req_tvalid && req_tready;

   srw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_last  (req_tlast),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid)
   );

   srw_datapath #(
      .MAX_RECORDS    (MAX_RECORDS),
      .MAX_WEIGHT_SUM (MAX_WEIGHT_SUM)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_priority (req_tdata[15:0]),
      .req_weight   (req_tdata[31:16]),
      .req_blank    (req_tuser),
      .req_random   (req_tdata[63:32]),
      .res_found    (res_found),
      .res_index    (res_index),
      .res_error    (res_error)
   );

   assign rsp_tdata = {7'b0, res_error, res_index};
   assign rsp_tuser = res_found;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import srw_pkg::*;

   localparam int MAX_RECORDS    = 64;
   localparam int MAX_WEIGHT_SUM = 1024;
   localparam int TARGET_ITEMS   = 2000;
   localparam int QUIET_ITEMS    = 1700;   // past this point nobody idles
   localparam int HOLD_CYCLES    = 400;    // long result-side hold-off
   localparam int DRAIN_CYCLES   = 250;    // room for the slowest selection
   localparam int CYCLE_LIMIT    = 1000000;

   // one record item as it goes into the block
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [WGT_W-1:0]  wgt;
      logic              blank;
      logic [RND_W-1:0]  rnd;
      logic              last;
   } record_item_type;

   // one selection result
   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] index;
      err_kind_type       kind;
   } pick_type;

   // directed row: record, whether the result is typed in, and that result
   typedef struct packed {
      record_item_type rec;
      logic            typed;
      pick_type        want;
   } directed_row_type;

   localparam pick_type NO_PICK   = '{1'b0, 6'd0, ERR_NONE};
   localparam pick_type ZERO_SUM  = '{1'b0, 6'd0, ERR_ZERO_SUM};
   localparam pick_type OVER_SUM  = '{1'b0, 6'd0, ERR_OVER_LIMIT};
   localparam pick_type BLANK_HIT = '{1'b0, 6'd0, ERR_BLANK};
   localparam pick_type FIRST_HIT = '{1'b1, 6'd0, ERR_NONE};

   localparam int DIRECTED_ROWS = 21;

   // Directed table. Typed results only where obvious; the rest go through
   // the predictor. An empty set cannot be built, since the first record of a
   // set is always stored.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // single record sets right after reset: zero weight, all-ones values
      '{'{16'h0000, 16'd0,    1'b0, 32'h0000_0000, 1'b1}, 1'b1, ZERO_SUM},
      '{'{16'hFFFF, 16'd1,    1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1, FIRST_HIT},
      // sum exactly at the limit, then one over it, then full weight
      '{'{16'h0000, 16'd1024, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1, FIRST_HIT},
      '{'{16'h0000, 16'd1025, 1'b0, 32'h0000_0000, 1'b1}, 1'b1, OVER_SUM},
      '{'{16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b1, OVER_SUM},
      // single blank record is always the pick
      '{'{16'h0005, 16'd7,    1'b1, 32'h0000_0000, 1'b1}, 1'b1, BLANK_HIT},
      // lowest group is {1,1}, last record has a higher priority
      '{'{16'h0003, 16'd10,   1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0001, 16'd4,    1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0001, 16'd6,    1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0002, 16'd100,  1'b0, 32'h0000_0005, 1'b1}, 1'b0, NO_PICK},
      // lowest group weighs nothing although others do
      '{'{16'h0009, 16'd500,  1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0008, 16'd0,    1'b0, 32'h0000_0000, 1'b1}, 1'b1, ZERO_SUM},
      // group sum goes over the limit only with the last record
      '{'{16'h0004, 16'd600,  1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0004, 16'd600,  1'b0, 32'h1234_5678, 1'b1}, 1'b1, OVER_SUM},
      // zero-weight blank member leads the group and must be skipped
      '{'{16'h0007, 16'd0,    1'b1, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0007, 16'd3,    1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0007, 16'd3,    1'b1, 32'h0000_0004, 1'b1}, 1'b0, NO_PICK},
      // remainder lands exactly on a running sum boundary
      '{'{16'h0000, 16'd1,    1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h0000, 16'd1,    1'b0, 32'h8000_0001, 1'b1}, 1'b0, NO_PICK},
      // blank record in the group but not chosen
      '{'{16'h000C, 16'd5,    1'b0, 32'h0000_0000, 1'b0}, 1'b0, NO_PICK},
      '{'{16'h000C, 16'd5,    1'b1, 32'h0000_0003, 1'b1}, 1'b0, NO_PICK}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   // predictor's copy of the record store
   logic [PRIO_W-1:0] stored_prio  [MAX_RECORDS];
   logic [WGT_W-1:0]  stored_wgt   [MAX_RECORDS];
   logic              stored_blank [MAX_RECORDS];
   int                stored_count;
   logic [PRIO_W-1:0] best_prio;
   logic              store_spilled;

   pick_type expected_picks [$];
   pick_type oldest_pick;

   bit bursts_on    = 1'b1;
   bit hold_request = 1'b0;
   int cycle_count  = 0;
   int mismatches   = 0;
   int picks_seen   = 0;
   int kind_seen [5];
   int records_sent = 0;
   int sets_sent    = 0;

   srv_weighted_record_select #(
      .MAX_RECORDS    (MAX_RECORDS),
      .MAX_WEIGHT_SUM (MAX_WEIGHT_SUM)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Store one record, and on the last one work out the weighted pick.
   // Returns 1 when the record causes a result.
   function automatic bit predict_selection(input record_item_type it,
                                            output pick_type pick);
      int unsigned group_sum;
      int unsigned running;
      logic [RND_W-1:0] remainder;
      int chosen;
      int k;
      pick = NO_PICK;
      if (stored_count < MAX_RECORDS) begin
         stored_prio[stored_count]  = it.prio;
         stored_wgt[stored_count]   = it.wgt;
         stored_blank[stored_count] = it.blank;
         stored_count++;
         if (it.prio < best_prio) begin
            best_prio = it.prio;
         end
      end else begin
         store_spilled = 1'b1;   // record dropped, table full
      end
      if (!it.last) begin
         return 1'b0;
      end
      group_sum = 0;
      for (k = 0; k < stored_count; k++) begin
         if (stored_prio[k] == best_prio) begin
            group_sum += stored_wgt[k];
         end
      end
      // same check order as the block: empty, full, zero, over, blank
      if (stored_count == 0) begin
         pick.kind = ERR_EMPTY;
      end else if (store_spilled) begin
         pick.kind = ERR_OVER_LIMIT;
      end else if (group_sum == 0) begin
         pick.kind = ERR_ZERO_SUM;
      end else if (group_sum > MAX_WEIGHT_SUM) begin
         pick.kind = ERR_OVER_LIMIT;
      end else begin
         remainder = it.rnd % group_sum;
         running = 0;
         chosen = 0;
         for (k = 0; k < stored_count; k++) begin
            if (stored_prio[k] == best_prio) begin
               running += stored_wgt[k];
               if (running > remainder) begin
                  chosen = k;
                  break;
               end
            end
         end
         if (stored_blank[chosen]) begin
            pick.kind = ERR_BLANK;
         end else begin
            pick.found = 1'b1;
            pick.index = chosen[INDEX_W-1:0];
         end
      end
      stored_count  = 0;
      best_prio     = '1;
      store_spilled = 1'b0;
      return 1'b1;
   endfunction

   // Offer one record from the falling edge, optionally after an idle burst
   // with junk on the bus, and return at the rising edge that takes it.
   task automatic offer_record(input record_item_type it);
      int gap;
      @(negedge clock);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         req_tuser  <= 1'($urandom_range(0, 1));
         req_tlast  <= 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.rnd, it.wgt, it.prio};
      req_tuser  <= it.blank;
      req_tlast  <= it.last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      records_sent++;
      if (it.last) begin
         sets_sent++;
      end
   endtask

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker, oldest expectation first
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_picks.size() == 0) begin
            $error("unexpected result item: found %0b index %0d kind %0d",
                   rsp_tuser, rsp_tdata[5:0], rsp_tdata[8:6]);
            mismatches++;
         end else begin
            oldest_pick = expected_picks.pop_front();
            if (rsp_tuser !== oldest_pick.found) begin
               $error("found: expected %0b, actual %0b", oldest_pick.found, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[5:0] !== oldest_pick.index) begin
               $error("selected_index: expected %0d, actual %0d",
                      oldest_pick.index, rsp_tdata[5:0]);
               mismatches++;
            end
            if (rsp_tdata[8:6] !== oldest_pick.kind) begin
               $error("error_kind: expected %0d, actual %0d",
                      oldest_pick.kind, rsp_tdata[8:6]);
               mismatches++;
            end
            picks_seen++;
            kind_seen[oldest_pick.kind]++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_picks.size());
         $display("srv_weighted_record_select: mismatch");
         $finish;
      end
   end

   initial begin
      record_item_type rec;
      pick_type        pick;
      int              set_no;
      int              set_size;
      int              pool;
      int              weight_cap;
      int              n;
      logic [PRIO_W-1:0] prio_base;
      stored_count  = 0;
      best_prio     = '1;
      store_spilled = 1'b0;
      foreach (kind_seen[k]) begin
         kind_seen[k] = 0;
      end

      // reset released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer_record(DIRECTED[i].rec);
         if (predict_selection(DIRECTED[i].rec, pick)) begin
            if (DIRECTED[i].typed) begin
               expected_picks.push_back(DIRECTED[i].want);
            end else begin
               expected_picks.push_back(pick);
            end
         end
      end

      // Random part: whole sets of records. Priorities come from a small pool
      // so groups form; weights scale with set size so most sums stay legal.
      // A few sets fill the table exactly or spill past it.
      set_no = 0;
      while (records_sent < TARGET_ITEMS) begin
         case (set_no % 40)
            7:       set_size = MAX_RECORDS;
            23:      set_size = MAX_RECORDS + $urandom_range(1, 6);
            31:      set_size = $urandom_range(9, 30);
            default: set_size = $urandom_range(1, 8);
         endcase
         pool = $urandom_range(1, 4);
         case ($urandom_range(0, 3))
            0:       prio_base = '0;
            1:       prio_base = 16'hFFFC;
            default: prio_base = PRIO_W'($urandom_range(0, 16'hFFFC));
         endcase
         weight_cap = (2 * MAX_WEIGHT_SUM) / set_size;
         if (weight_cap < 1) begin
            weight_cap = 1;
         end
         if (set_no == 60) begin
            hold_request = 1'b1;   // receiver stops; block must back up
         end
         for (n = 0; n < set_size; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               rec.prio = PRIO_W'($urandom);   // stray priority
            end else begin
               rec.prio = PRIO_W'(prio_base + $urandom_range(0, pool - 1));
            end
            case ($urandom_range(0, 15))
               0:       rec.wgt = '0;
               1:       rec.wgt = WGT_W'($urandom);
               default: rec.wgt = WGT_W'($urandom_range(0, weight_cap));
            endcase
            rec.blank = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 15))
               0:       rec.rnd = '0;
               1:       rec.rnd = '1;
               default: rec.rnd = $urandom;
            endcase
            rec.last = (n == set_size - 1);
            if (records_sent >= QUIET_ITEMS) begin
               bursts_on = 1'b0;
            end
            offer_record(rec);
            if (predict_selection(rec, pick)) begin
               expected_picks.push_back(pick);
            end
         end
         set_no++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then leave room for any stray result
      while (expected_picks.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d records in %0d sets, %0d results in %0d cycles",
               records_sent, sets_sent, picks_seen, cycle_count);
      $display("picks %0d, zero sum %0d, blank %0d, over limit or full %0d",
               kind_seen[ERR_NONE], kind_seen[ERR_ZERO_SUM], kind_seen[ERR_BLANK],
               kind_seen[ERR_OVER_LIMIT]);
      if (mismatches == 0) begin
         $display("srv_weighted_record_select: match");
      end else begin
         $display("srv_weighted_record_select: mismatch");
      end
      $finish;
   end

endmodule
